// ===== rtl/core/chbh_pkg.sv =====
// Shared types and constants for the chained block hash unit.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chbh_pkg;

  localparam int unsigned CHBH_NUM_WORDS   = 8;
  localparam int unsigned CHBH_QUEUE_DEPTH = 4;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned WINDOW_W   = 24;
  localparam int unsigned FOLD_SHIFT = 16;

  localparam logic [HASH_W-1:0] MUL_B = 32'd2747636419;
  localparam logic [HASH_W-1:0] MUL_C = 32'd2654435769;
  // 31 - MUL_B modulo 2^32: the two mix-state products folded into one.
  localparam logic [HASH_W-1:0] MIX_K = 32'd31 - MUL_B;

  typedef enum logic {
    JOB_POS,
    JOB_EMIT
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [HASH_W-1:0]  window;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/chained_block_hash_256_unit.sv =====
// Chained block hash unit: byte-serial hash with eight 32-bit chained words.
// Top level; instantiates chbh_front, chbh_queue and chbh_back; uses chbh_pkg.
//
// Each item carries one message byte; a message ends with an item that has
// in_end_of_message set, after which NUM_WORDS result items (one hash word
// each, index 0 first) appear in order. The front end takes one item per
// cycle while the job queue has room, except that after a message end it
// holds in_full high while the up to three waiting positions and the emit
// job are queued. For every byte position the back end runs a mix step and
// then updates the words in order on the single shared 32x32 multiplier,
// which each word update uses three times in a chain. A message end adds the
// up to three padded positions still waiting, then the emit job, whose
// NUM_WORDS result items stall while a result is not taken, and a reseeding
// pass; the same reseed pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module chained_block_hash_256_unit
  import chbh_pkg::*;
#(
  parameter int unsigned NUM_WORDS   = CHBH_NUM_WORDS,
  parameter int unsigned QUEUE_DEPTH = CHBH_QUEUE_DEPTH
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  input  wire logic        in_no_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_hash_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t push_job;
  job_t pop_job;

  chbh_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .in_no_byte        (in_no_byte),
    .q_push            (q_push),
    .q_job             (push_job),
    .q_full            (q_full)
  );

  chbh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  chbh_back #(
    .NUM_WORDS (NUM_WORDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_job          (pop_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_hash_word  (out_hash_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .out_empty      (out_empty),
    .out_pop        (out_pop)
  );

endmodule

`default_nettype wire

// ===== rtl/core/chbh_front.sv =====
// Front end of the chained block hash unit: holds the byte window and turns
// accepted items into position and emit jobs for the back end.
// Depends on chbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chbh_front
  import chbh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  input  wire logic        in_no_byte,
  output logic             q_push,
  output job_t             q_job,
  input  wire logic        q_full
);

  logic [WINDOW_W-1:0] window_r;
  logic [1:0]          fill_r;
  logic                flush_r;
  logic                accept;
  logic                full_pos;

  assign in_full  = flush_r || q_full;
  assign accept   = in_push && !in_full;
  assign full_pos = accept && !in_no_byte && (fill_r == 2'd3);

  always_comb begin
    q_push      = 1'b0;
    q_job.kind  = JOB_POS;
    q_job.window = {in_data_byte, window_r};
    if (full_pos) begin
      q_push = 1'b1;
    end else if (flush_r && !q_full) begin
      q_push = 1'b1;
      if (fill_r != 2'd0) begin
        q_job.window = {8'd0, window_r};
      end else begin
        q_job.kind   = JOB_EMIT;
        q_job.window = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= 2'd0;
      flush_r  <= 1'b0;
    end else if (accept) begin
      if (!in_no_byte) begin
        case (fill_r)
          2'd0: begin
            window_r[7:0] <= in_data_byte;
            fill_r        <= 2'd1;
          end
          2'd1: begin
            window_r[15:8] <= in_data_byte;
            fill_r         <= 2'd2;
          end
          2'd2: begin
            window_r[23:16] <= in_data_byte;
            fill_r          <= 2'd3;
          end
          default: begin
            window_r <= {in_data_byte, window_r[23:8]};
          end
        endcase
      end
      flush_r <= in_end_of_message;
    end else if (flush_r && !q_full) begin
      if (fill_r != 2'd0) begin
        window_r <= {8'd0, window_r[23:8]};
        fill_r   <= fill_r - 2'd1;
      end else begin
        window_r <= '0;
        flush_r  <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("Job pushed into a full queue.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (flush_r && !q_full && fill_r == 2'd0) |-> (q_push && q_job.kind == JOB_EMIT))
    else $error("Flush finished without an emit job.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_message) |=> flush_r)
    else $error("Message end did not start a flush.");

endmodule

`default_nettype wire

// ===== rtl/core/chbh_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on chbh_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module chbh_queue
  import chbh_pkg::*;
#(
  parameter int unsigned DEPTH = CHBH_QUEUE_DEPTH
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/chbh_back.sv =====
// Back end of the chained block hash unit: mix-state fold, word-by-word
// chain update on one shared multiplier, result emission and reseeding.
// Depends on chbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chbh_back
  import chbh_pkg::*;
#(
  parameter int unsigned NUM_WORDS = CHBH_NUM_WORDS
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire job_t               q_job,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic [HASH_W-1:0]       out_hash_word,
  output logic [2:0]              out_word_index,
  output logic                    out_last_word,
  output logic                    out_empty,
  input  wire logic               out_pop
);

  localparam int unsigned IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

  typedef enum logic [2:0] {
    ST_SEED,
    ST_IDLE,
    ST_MIX_MUL,
    ST_MIX_ADD,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_EMIT
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  idx_r;
  logic [HASH_W-1:0] mix_r;
  logic [HASH_W-1:0] prev_r;
  logic [HASH_W-1:0] prod_r;
  logic [HASH_W-1:0] window_r;
  logic [HASH_W-1:0] words_r [NUM_WORDS];
  logic              out_valid_r;

  logic [HASH_W-1:0] idx_ext;
  logic [HASH_W-1:0] cur_word;
  logic [HASH_W-1:0] w1_val;
  logic [HASH_W-1:0] folded;
  logic [HASH_W-1:0] mul_a;
  logic [HASH_W-1:0] mul_b;
  logic [HASH_W-1:0] mul_p;
  logic              out_free;
  logic              out_load;

  assign idx_ext   = HASH_W'(idx_r);
  assign cur_word  = words_r[idx_r];
  assign w1_val    = ((cur_word + ((mix_r >> idx_r) ^ prev_r)) ^ (prev_r + idx_ext)) ^ MUL_B;
  assign folded    = prod_r ^ (prod_r >> FOLD_SHIFT);
  assign out_free  = !out_valid_r || out_pop;
  assign out_load  = (state_r == ST_EMIT) && out_free;
  assign out_empty = !out_valid_r;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    case (state_r)
      ST_MIX_MUL: begin
        mul_a = mix_r;
        mul_b = MIX_K;
      end
      ST_W1: begin
        mul_a = w1_val;
        mul_b = MUL_C + idx_ext;
      end
      default: begin
        mul_a = folded;
        mul_b = MUL_C;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r    <= 1'b1;
        out_hash_word  <= cur_word;
        out_word_index <= 3'(idx_r);
        out_last_word  <= (idx_r == LAST_IDX);
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_SEED: begin
          for (int i = 0; i < NUM_WORDS; i++) begin
            words_r[i] <= '0;
          end
          mix_r   <= '0;
          prev_r  <= '0;
          idx_r   <= '0;
          state_r <= ST_W1;
        end
        ST_IDLE: begin
          if (!q_empty) begin
            window_r <= q_job.window;
            idx_r    <= '0;
            state_r  <= (q_job.kind == JOB_EMIT) ? ST_EMIT : ST_MIX_MUL;
          end
        end
        ST_MIX_MUL: begin
          prod_r  <= mul_p;
          state_r <= ST_MIX_ADD;
        end
        ST_MIX_ADD: begin
          mix_r   <= prod_r + (mix_r ^ MUL_C) + window_r;
          prev_r  <= prod_r + (mix_r ^ MUL_C) + window_r;
          state_r <= ST_W1;
        end
        ST_W1: begin
          prod_r  <= mul_p;
          state_r <= ST_W2;
        end
        ST_W2: begin
          prod_r  <= mul_p;
          state_r <= ST_W3;
        end
        ST_W3: begin
          words_r[idx_r] <= mul_p;
          prev_r         <= mul_p;
          if (idx_r == LAST_IDX) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_W1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (idx_r == LAST_IDX) begin
              state_r <= ST_SEED;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == ST_EMIT))
    else $error("Result loaded outside emission.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_W3 && idx_r == LAST_IDX) |=> (state_r == ST_IDLE))
    else $error("Chain pass did not end after the last word.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED) |=> (state_r == ST_W1 && idx_r == '0 && mix_r == '0))
    else $error("Reseed did not start a clean chain pass.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> out_valid_r)
    else $error("Waiting result item was dropped.");

endmodule

`default_nettype wire
